@@ design/lock_condvar_queue_manager_unit_assert.svh @@
// Assertion macros shared by the RTL of the lock and condition queue manager
`ifndef LOCK_CONDVAR_QUEUE_MANAGER_UNIT_ASSERT_SVH
`define LOCK_CONDVAR_QUEUE_MANAGER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LCQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LCQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCQ_ASSERT(lbl, prop, msg)
`define LCQ_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ design/lcq_pkg.sv @@
// Package: sizes, opcodes, status codes and result type of the queue manager
`timescale 1ns / 1ps
package lcq_pkg;
  localparam int THREAD_SLOTS = 16;
  localparam int LOCK_SLOTS   = 16;
  localparam int COND_SLOTS   = 16;
  localparam int TID_W        = 4;
  localparam int LID_W        = 4;
  localparam int CID_W        = 4;
  localparam int CNT_W        = 5;
  localparam int MAX_RESULTS  = 16;

  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_CREATE    = 4'd1,
    OP_DISPATCH  = 4'd2,
    OP_YIELD     = 4'd3,
    OP_FINISH    = 4'd4,
    OP_LOCK      = 4'd5,
    OP_UNLOCK    = 4'd6,
    OP_WAIT      = 4'd7,
    OP_SIGNAL    = 4'd8,
    OP_BROADCAST = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_INIT = 3'd1,
    ST_REINIT   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic             last;
    logic             blocked;
    logic             granted;
    logic             retired;
    logic [TID_W-1:0] moved_thread;
    logic             moved_valid;
    logic [2:0]       status;
  } res_t;
endpackage

@@ design/lcq_ram.sv @@
// Generic synchronous RAM, one write and one registered read port, write-first
`timescale 1ns / 1ps
module lcq_ram #(
  parameter int W = 4,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/lock_condvar_queue_manager_unit.sv @@
// Top level: sequencer and queue state of the lock and condition queue manager
// Broadcast gives one result per cycle while the output is not stalled, paced by the link memory read loop.
// One item at a time; next input taken once the last result is in the output register.
// Synchronous reset clears initialized, held bits, finished marks and all queue counts.
`timescale 1ns / 1ps
`include "lock_condvar_queue_manager_unit_assert.svh"
module lock_condvar_queue_manager_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // opcode, thread_id, lock_id, cond_id
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // status, moved_valid, moved_thread, retired, granted, blocked
  output logic        m_tlast
);
  localparam int TW = lcq_pkg::TID_W;
  localparam int CW = lcq_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_HAND, S_CPUSH, S_SIG, S_BC} state_t;

  state_t state, state_next;
  logic [3:0] op_r, op_next;
  logic [TW-1:0] tid_r, tid_next;
  logic [lcq_pkg::LID_W-1:0] lk_r, lk_next;
  logic [lcq_pkg::CID_W-1:0] cv_r, cv_next;
  logic initialized, initialized_next;
  logic [lcq_pkg::THREAD_SLOTS-1:0] fin, fin_next;
  logic [lcq_pkg::LOCK_SLOTS-1:0] held, held_next;
  logic [CW-1:0] lcnt [lcq_pkg::LOCK_SLOTS];
  logic [CW-1:0] lcnt_next [lcq_pkg::LOCK_SLOTS];
  logic [CW-1:0] ccnt [lcq_pkg::COND_SLOTS];
  logic [CW-1:0] ccnt_next [lcq_pkg::COND_SLOTS];
  logic [TW-1:0] rhead, rhead_next, rtail, rtail_next;
  logic [CW-1:0] rcnt, rcnt_next;
  logic [TW-1:0] bc_head, bc_head_next;
  logic [CW-1:0] bc_k, bc_k_next;
  logic out_valid, out_valid_next;
  lcq_pkg::res_t out_q, out_next;

  logic link_we;
  logic [TW-1:0] link_wa, link_wd, link_ra, lnk;
  logic lk_we;
  logic [lcq_pkg::LID_W-1:0] lk_ra;
  logic [2*TW-1:0] lk_wd, lk_rd;
  logic cd_we;
  logic [lcq_pkg::CID_W-1:0] cd_ra;
  logic [2*TW-1:0] cd_wd, cd_rd;

  lcq_ram #(.W(TW), .D(lcq_pkg::THREAD_SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(link_ra), .rdata(lnk)
  );
  lcq_ram #(.W(2*TW), .D(lcq_pkg::LOCK_SLOTS)) u_lockq (
    .clk(clk), .we(lk_we), .waddr(lk_r), .wdata(lk_wd),
    .raddr(lk_ra), .rdata(lk_rd)
  );
  lcq_ram #(.W(2*TW), .D(lcq_pkg::COND_SLOTS)) u_condq (
    .clk(clk), .we(cd_we), .waddr(cv_r), .wdata(cd_wd),
    .raddr(cd_ra), .rdata(cd_rd)
  );

  logic [TW-1:0] lh, lt, ch, ct;
  logic rfull, ofree;
  assign lh = lk_rd[2*TW-1:TW];
  assign lt = lk_rd[TW-1:0];
  assign ch = cd_rd[2*TW-1:TW];
  assign ct = cd_rd[TW-1:0];
  assign rfull = rcnt >= CW'(lcq_pkg::THREAD_SLOTS);
  assign ofree = !out_valid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_q.blocked, out_q.granted, out_q.retired,
                     out_q.moved_thread, out_q.moved_valid, out_q.status};
  assign m_tlast  = out_q.last;

  always_comb begin
    logic emit;
    logic done;
    logic [TW-1:0] newh;
    logic [CW-1:0] cafter;
    lcq_pkg::res_t res;
    emit = 1'b0;
    done = 1'b0;
    newh = '0;
    cafter = '0;
    res = '0;
    res.last = 1'b1;
    state_next = state;
    op_next = op_r;
    tid_next = tid_r;
    lk_next = lk_r;
    cv_next = cv_r;
    initialized_next = initialized;
    fin_next = fin;
    held_next = held;
    lcnt_next = lcnt;
    ccnt_next = ccnt;
    rhead_next = rhead;
    rtail_next = rtail;
    rcnt_next = rcnt;
    bc_head_next = bc_head;
    bc_k_next = bc_k;
    out_valid_next = out_valid && !m_tready;
    out_next = out_q;
    link_we = 1'b0;
    link_wa = rtail;
    link_wd = tid_r;
    link_ra = rhead;
    lk_we = 1'b0;
    lk_wd = lk_rd;
    lk_ra = lk_r;
    cd_we = 1'b0;
    cd_wd = cd_rd;
    cd_ra = cv_r;

    case (state)
      S_IDLE: begin
        lk_ra = s_tdata[11:8];
        cd_ra = s_tdata[15:12];
        if (s_tvalid) begin
          op_next = s_tdata[3:0];
          tid_next = s_tdata[7:4];
          lk_next = s_tdata[11:8];
          cv_next = s_tdata[15:12];
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (op_r == lcq_pkg::OP_DISPATCH) begin
          link_ra = rhead;
        end else if (op_r == lcq_pkg::OP_SIGNAL || op_r == lcq_pkg::OP_BROADCAST) begin
          link_ra = ch;
        end else begin
          link_ra = lh;
        end
        if (ofree) begin
          state_next = S_IDLE;
          emit = 1'b1;
          if (op_r > lcq_pkg::OP_BROADCAST) begin
            res.status = lcq_pkg::ST_OK;
          end else if (op_r == lcq_pkg::OP_INIT && initialized) begin
            res.status = lcq_pkg::ST_REINIT;
          end else if (op_r != lcq_pkg::OP_INIT && !initialized) begin
            res.status = lcq_pkg::ST_NOT_INIT;
          end else begin
            case (op_r)
              lcq_pkg::OP_INIT, lcq_pkg::OP_CREATE, lcq_pkg::OP_YIELD,
              lcq_pkg::OP_FINISH: begin
                if (op_r == lcq_pkg::OP_INIT) begin
                  initialized_next = 1'b1;
                  fin_next[tid_r] = 1'b0;
                end
                if (rfull) begin
                  res.status = lcq_pkg::ST_OVERFLOW;
                end else begin
                  if (op_r == lcq_pkg::OP_CREATE) fin_next[tid_r] = 1'b0;
                  if (op_r == lcq_pkg::OP_FINISH) fin_next[tid_r] = 1'b1;
                  if (rcnt == '0) begin
                    rhead_next = tid_r;
                  end else begin
                    link_we = 1'b1;
                    link_wa = rtail;
                    link_wd = tid_r;
                  end
                  rtail_next = tid_r;
                  rcnt_next = rcnt + 1'b1;
                  res.moved_valid = 1'b1;
                  res.moved_thread = tid_r;
                end
              end
              lcq_pkg::OP_DISPATCH: begin
                if (rcnt == '0) begin
                  res.status = lcq_pkg::ST_EMPTY;
                end else begin
                  if (rcnt > CW'(1)) rhead_next = lnk;
                  rcnt_next = rcnt - 1'b1;
                  res.retired = fin[rhead];
                  fin_next[rhead] = 1'b0;
                  res.moved_valid = 1'b1;
                  res.moved_thread = rhead;
                end
              end
              lcq_pkg::OP_LOCK: begin
                if (!held[lk_r]) begin
                  held_next[lk_r] = 1'b1;
                  res.granted = 1'b1;
                end else if (lcnt[lk_r] >= CW'(lcq_pkg::THREAD_SLOTS)) begin
                  res.status = lcq_pkg::ST_OVERFLOW;
                end else begin
                  if (lcnt[lk_r] == '0) begin
                    newh = tid_r;
                  end else begin
                    newh = lh;
                    link_we = 1'b1;
                    link_wa = lt;
                    link_wd = tid_r;
                  end
                  lk_we = 1'b1;
                  lk_wd = {newh, tid_r};
                  lcnt_next[lk_r] = lcnt[lk_r] + 1'b1;
                  res.blocked = 1'b1;
                end
              end
              lcq_pkg::OP_UNLOCK, lcq_pkg::OP_WAIT: begin
                if ((lcnt[lk_r] != '0 && rfull) || (op_r == lcq_pkg::OP_WAIT &&
                    ccnt[cv_r] >= CW'(lcq_pkg::THREAD_SLOTS))) begin
                  res.status = lcq_pkg::ST_OVERFLOW;
                end else if (lcnt[lk_r] != '0) begin
                  emit = 1'b0;
                  state_next = S_HAND;
                end else begin
                  held_next[lk_r] = 1'b0;
                  if (op_r == lcq_pkg::OP_WAIT) begin
                    if (ccnt[cv_r] == '0) begin
                      newh = tid_r;
                    end else begin
                      newh = ch;
                      link_we = 1'b1;
                      link_wa = ct;
                      link_wd = tid_r;
                    end
                    cd_we = 1'b1;
                    cd_wd = {newh, tid_r};
                    ccnt_next[cv_r] = ccnt[cv_r] + 1'b1;
                    res.blocked = 1'b1;
                  end
                end
              end
              lcq_pkg::OP_SIGNAL: begin
                if (ccnt[cv_r] == '0) begin
                  res.status = lcq_pkg::ST_OK;
                end else if (rfull) begin
                  res.status = lcq_pkg::ST_OVERFLOW;
                end else begin
                  emit = 1'b0;
                  state_next = S_SIG;
                end
              end
              lcq_pkg::OP_BROADCAST: begin
                if (ccnt[cv_r] == '0 || rfull) begin
                  res.status = (ccnt[cv_r] != '0) ? lcq_pkg::ST_OVERFLOW : lcq_pkg::ST_OK;
                end else begin
                  emit = 1'b0;
                  bc_head_next = ch;
                  bc_k_next = '0;
                  state_next = S_BC;
                end
              end
              default: begin
                res.status = lcq_pkg::ST_OK;
              end
            endcase
          end
        end
      end
      S_HAND: begin
        link_ra = lh;
        if (ofree) begin
          newh = (lcnt[lk_r] > CW'(1)) ? lnk : lh;
          lk_we = 1'b1;
          lk_wd = {newh, lt};
          lcnt_next[lk_r] = lcnt[lk_r] - 1'b1;
          if (rcnt == '0) begin
            rhead_next = lh;
          end else begin
            link_we = 1'b1;
            link_wa = rtail;
            link_wd = lh;
          end
          rtail_next = lh;
          rcnt_next = rcnt + 1'b1;
          bc_head_next = lh;
          if (op_r == lcq_pkg::OP_WAIT) begin
            state_next = S_CPUSH;
          end else begin
            res.moved_valid = 1'b1;
            res.moved_thread = lh;
            emit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_CPUSH: begin
        if (ofree) begin
          if (ccnt[cv_r] == '0) begin
            newh = tid_r;
          end else begin
            newh = ch;
            link_we = 1'b1;
            link_wa = ct;
            link_wd = tid_r;
          end
          cd_we = 1'b1;
          cd_wd = {newh, tid_r};
          ccnt_next[cv_r] = ccnt[cv_r] + 1'b1;
          res.moved_valid = 1'b1;
          res.moved_thread = bc_head;
          res.blocked = 1'b1;
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SIG: begin
        link_ra = ch;
        if (ofree) begin
          newh = (ccnt[cv_r] > CW'(1)) ? lnk : ch;
          cd_we = 1'b1;
          cd_wd = {newh, ct};
          ccnt_next[cv_r] = ccnt[cv_r] - 1'b1;
          if (rcnt == '0) begin
            rhead_next = ch;
          end else begin
            link_we = 1'b1;
            link_wa = rtail;
            link_wd = ch;
          end
          rtail_next = ch;
          rcnt_next = rcnt + 1'b1;
          res.moved_valid = 1'b1;
          res.moved_thread = ch;
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BC: begin
        link_ra = ofree ? lnk : bc_head;
        if (ofree) begin
          cafter = ccnt[cv_r] - 1'b1;
          ccnt_next[cv_r] = cafter;
          if (rcnt == '0) begin
            rhead_next = bc_head;
          end else begin
            link_we = 1'b1;
            link_wa = rtail;
            link_wd = bc_head;
          end
          rtail_next = bc_head;
          rcnt_next = rcnt + 1'b1;
          bc_k_next = bc_k + 1'b1;
          bc_head_next = lnk;
          done = (cafter == '0) || (rcnt_next >= CW'(lcq_pkg::THREAD_SLOTS)) ||
                 (bc_k_next == CW'(lcq_pkg::MAX_RESULTS));
          res.moved_valid = 1'b1;
          res.moved_thread = bc_head;
          res.last = done;
          res.status = (done && cafter != '0) ? lcq_pkg::ST_OVERFLOW : lcq_pkg::ST_OK;
          emit = 1'b1;
          if (done) begin
            cd_we = 1'b1;
            cd_wd = {((cafter != '0) ? lnk : bc_head), ct};
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
      out_next = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      initialized <= 1'b0;
      fin <= '0;
      held <= '0;
      for (int i = 0; i < lcq_pkg::LOCK_SLOTS; i++) lcnt[i] <= '0;
      for (int i = 0; i < lcq_pkg::COND_SLOTS; i++) ccnt[i] <= '0;
      rhead <= '0;
      rtail <= '0;
      rcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      initialized <= initialized_next;
      fin <= fin_next;
      held <= held_next;
      lcnt <= lcnt_next;
      ccnt <= ccnt_next;
      rhead <= rhead_next;
      rtail <= rtail_next;
      rcnt <= rcnt_next;
      out_valid <= out_valid_next;
      op_r <= op_next;
      tid_r <= tid_next;
      lk_r <= lk_next;
      cv_r <= cv_next;
      bc_head <= bc_head_next;
      bc_k <= bc_k_next;
      out_q <= out_next;
    end
  end

  `LCQ_ASSERT(a_rcnt_bound, rcnt <= CW'(lcq_pkg::THREAD_SLOTS), "ready count beyond slots")
  `LCQ_ASSERT(a_accept_dec, (s_tvalid && s_tready) |=> (state == S_DEC), "accept not decoded")
  `LCQ_ASSERT(a_moved_zero, (out_valid && !out_q.moved_valid) |-> (out_q.moved_thread == '0),
              "moved thread set without moved flag")
  `LCQ_ASSERT_RST(a_rst_clear, rst |=> (!initialized && !out_valid && rcnt == '0),
                  "reset did not clear state")
endmodule

@@ verif/lock_condvar_queue_manager_unit_test.sv @@
// Testbench: random and directed checks of the lock and condition queue manager
`timescale 1ns / 1ps
module lock_condvar_queue_manager_unit_test;
  localparam int NQ = 1 + lcq_pkg::LOCK_SLOTS + lcq_pkg::COND_SLOTS;  // ready, lock, cond
  localparam int RQ = 0;

  typedef struct {
    logic [15:0] data;
    bit          drain;
  } req_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // opcode, thread_id, lock_id, cond_id
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;       // status, moved_valid, moved_thread, retired, granted, blocked
  logic        m_tlast;

  lock_condvar_queue_manager_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  req_t pending[$];
  lcq_pkg::res_t expected_results[$];
  int   n_sent = 0;
  int   n_mismatch = 0;
  int   hold_left = 0;
  bit   hold_done = 0;

  // shadow state of the synchronizer
  bit             sh_init;
  logic [3:0]     sh_link [lcq_pkg::THREAD_SLOTS];
  bit             sh_fin  [lcq_pkg::THREAD_SLOTS];
  bit             sh_held [lcq_pkg::LOCK_SLOTS];
  logic [3:0]     sh_head [NQ];
  logic [3:0]     sh_tail [NQ];
  int             sh_cnt  [NQ];

  function automatic void q_push(int q, logic [3:0] t);
    if (sh_cnt[q] == 0) sh_head[q] = t;
    else sh_link[sh_tail[q]] = t;
    sh_tail[q] = t;
    sh_cnt[q]++;
  endfunction

  function automatic logic [3:0] q_pop(int q);
    logic [3:0] t;
    t = sh_head[q];
    if (sh_cnt[q] > 1) sh_head[q] = sh_link[t];
    sh_cnt[q]--;
    return t;
  endfunction

  function automatic void add_result(logic [2:0] st, logic mv, logic [3:0] mt, logic ret,
                                     logic gr, logic bl, logic lst);
    lcq_pkg::res_t r;
    r.status = st; r.moved_valid = mv; r.moved_thread = mv ? mt : 4'd0;
    r.retired = ret; r.granted = gr; r.blocked = bl; r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void make_ready(logic [3:0] t);
    if (sh_cnt[RQ] >= lcq_pkg::THREAD_SLOTS)
      add_result(lcq_pkg::ST_OVERFLOW, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    else begin
      q_push(RQ, t);
      add_result(lcq_pkg::ST_OK, 1'b1, t, 1'b0, 1'b0, 1'b0, 1'b1);
    end
  endfunction

  function automatic void predict_sync(logic [15:0] d);
    logic [3:0] op, tid, lk, cv, t;
    int lq, cq, k;
    bit hand;
    op = d[3:0]; tid = d[7:4]; lk = d[11:8]; cv = d[15:12];
    lq = 1 + lk; cq = 1 + lcq_pkg::LOCK_SLOTS + cv;
    if (op > lcq_pkg::OP_BROADCAST) begin
      add_result(lcq_pkg::ST_OK, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      return;
    end
    if (op == lcq_pkg::OP_INIT) begin
      if (sh_init) add_result(lcq_pkg::ST_REINIT, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      else begin
        sh_init = 1'b1; sh_fin[tid] = 1'b0; make_ready(tid);
      end
      return;
    end
    if (!sh_init) begin
      add_result(lcq_pkg::ST_NOT_INIT, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      return;
    end
    case (op)
      lcq_pkg::OP_CREATE: begin
        if (sh_cnt[RQ] < lcq_pkg::THREAD_SLOTS) sh_fin[tid] = 1'b0;
        make_ready(tid);
      end
      lcq_pkg::OP_DISPATCH: begin
        if (sh_cnt[RQ] == 0)
          add_result(lcq_pkg::ST_EMPTY, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        else begin
          t = q_pop(RQ);
          add_result(lcq_pkg::ST_OK, 1'b1, t, sh_fin[t], 1'b0, 1'b0, 1'b1);
          sh_fin[t] = 1'b0;
        end
      end
      lcq_pkg::OP_YIELD: make_ready(tid);
      lcq_pkg::OP_FINISH: begin
        if (sh_cnt[RQ] < lcq_pkg::THREAD_SLOTS) sh_fin[tid] = 1'b1;
        make_ready(tid);
      end
      lcq_pkg::OP_LOCK: begin
        if (!sh_held[lk]) begin
          sh_held[lk] = 1'b1;
          add_result(lcq_pkg::ST_OK, 1'b0, 4'd0, 1'b0, 1'b1, 1'b0, 1'b1);
        end else if (sh_cnt[lq] >= lcq_pkg::THREAD_SLOTS)
          add_result(lcq_pkg::ST_OVERFLOW, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        else begin
          q_push(lq, tid);
          add_result(lcq_pkg::ST_OK, 1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1);
        end
      end
      lcq_pkg::OP_UNLOCK, lcq_pkg::OP_WAIT: begin
        hand = sh_cnt[lq] > 0;
        t = '0;
        if ((hand && sh_cnt[RQ] >= lcq_pkg::THREAD_SLOTS) ||
            (op == lcq_pkg::OP_WAIT && sh_cnt[cq] >= lcq_pkg::THREAD_SLOTS))
          add_result(lcq_pkg::ST_OVERFLOW, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        else begin
          if (hand) begin
            t = q_pop(lq); q_push(RQ, t);
          end else sh_held[lk] = 1'b0;
          if (op == lcq_pkg::OP_WAIT) q_push(cq, tid);
          add_result(lcq_pkg::ST_OK, hand, t, 1'b0, 1'b0, op == lcq_pkg::OP_WAIT, 1'b1);
        end
      end
      lcq_pkg::OP_SIGNAL: begin
        if (sh_cnt[cq] == 0)
          add_result(lcq_pkg::ST_OK, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        else if (sh_cnt[RQ] >= lcq_pkg::THREAD_SLOTS)
          add_result(lcq_pkg::ST_OVERFLOW, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        else make_ready(q_pop(cq));
      end
      default: begin
        k = 0;
        while (sh_cnt[cq] > 0 && sh_cnt[RQ] < lcq_pkg::THREAD_SLOTS &&
               k < lcq_pkg::MAX_RESULTS) begin
          t = q_pop(cq); q_push(RQ, t);
          add_result(lcq_pkg::ST_OK, 1'b1, t, 1'b0, 1'b0, 1'b0, 1'b0);
          k++;
        end
        if (k == 0)
          add_result(sh_cnt[cq] > 0 ? lcq_pkg::ST_OVERFLOW : lcq_pkg::ST_OK,
                     1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        else begin
          expected_results[$].status = sh_cnt[cq] > 0 ? lcq_pkg::ST_OVERFLOW : lcq_pkg::ST_OK;
          expected_results[$].last = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic logic [15:0] pack_op(logic [3:0] op, logic [3:0] tid, logic [3:0] lk,
                                          logic [3:0] cv);
    return {cv, lk, tid, op};
  endfunction

  function automatic void queue_op(logic [3:0] op, logic [3:0] tid, logic [3:0] lk,
                                   logic [3:0] cv, bit drain = 1'b0);
    req_t r;
    r.data = pack_op(op, tid, lk, cv);
    r.drain = drain;
    pending.push_back(r);
  endfunction

  function automatic logic [3:0] pick_id();
    return ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
  endfunction

  function automatic void queue_random();
    int w;
    logic [3:0] op;
    w = $urandom_range(0, 99);
    if (w < 12) op = lcq_pkg::OP_CREATE;
    else if (w < 20) op = lcq_pkg::OP_YIELD;
    else if (w < 28) op = lcq_pkg::OP_FINISH;
    else if (w < 52) op = lcq_pkg::OP_DISPATCH;
    else if (w < 67) op = lcq_pkg::OP_LOCK;
    else if (w < 77) op = lcq_pkg::OP_UNLOCK;
    else if (w < 88) op = lcq_pkg::OP_WAIT;
    else if (w < 93) op = lcq_pkg::OP_SIGNAL;
    else if (w < 97) op = lcq_pkg::OP_BROADCAST;
    else if (w < 98) op = lcq_pkg::OP_INIT;
    else op = 4'($urandom_range(10, 15));
    queue_op(op, 4'($urandom), pick_id(), pick_id());
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < lcq_pkg::THREAD_SLOTS; i++) begin
      sh_fin[i] = 1'b0; sh_held[i] = 1'b0; sh_link[i] = '0;
    end
    for (int i = 0; i < NQ; i++) begin
      sh_head[i] = '0; sh_tail[i] = '0; sh_cnt[i] = 0;
    end
    sh_init = 1'b0;
    // calls before init, unused opcode, init and re-init, create, finish, yield and dispatch
    queue_op(lcq_pkg::OP_LOCK, 4'd3, 4'd1, 4'd2);
    queue_op(lcq_pkg::OP_DISPATCH, 4'd0, 4'd0, 4'd0);
    queue_op(4'd15, 4'd15, 4'd15, 4'd15);
    queue_op(lcq_pkg::OP_INIT, 4'd15, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_INIT, 4'd1, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_DISPATCH, 4'd0, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_DISPATCH, 4'd0, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_CREATE, 4'd0, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_FINISH, 4'd5, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_YIELD, 4'd10, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_DISPATCH, 4'd0, 4'd0, 4'd0);
    queue_op(lcq_pkg::OP_DISPATCH, 4'd0, 4'd0, 4'd0);
    // lock contention, hand-off, wait and wake-up
    queue_op(lcq_pkg::OP_LOCK, 4'd1, 4'd15, 4'd0);
    queue_op(lcq_pkg::OP_LOCK, 4'd2, 4'd15, 4'd0);
    queue_op(lcq_pkg::OP_LOCK, 4'd3, 4'd15, 4'd0);
    queue_op(lcq_pkg::OP_WAIT, 4'd1, 4'd15, 4'd15);
    queue_op(lcq_pkg::OP_UNLOCK, 4'd0, 4'd15, 4'd0);
    queue_op(lcq_pkg::OP_UNLOCK, 4'd0, 4'd15, 4'd0);
    queue_op(lcq_pkg::OP_UNLOCK, 4'd0, 4'd15, 4'd0);
    queue_op(lcq_pkg::OP_SIGNAL, 4'd0, 4'd0, 4'd15);
    queue_op(lcq_pkg::OP_SIGNAL, 4'd0, 4'd0, 4'd1);
    queue_op(lcq_pkg::OP_WAIT, 4'd4, 4'd5, 4'd2);
    queue_op(lcq_pkg::OP_WAIT, 4'd6, 4'd5, 4'd2);
    queue_op(lcq_pkg::OP_BROADCAST, 4'd0, 4'd0, 4'd2);
    queue_op(lcq_pkg::OP_BROADCAST, 4'd0, 4'd0, 4'd3, 1'b1);
    for (int i = 0; i < 210; i++) begin
      if (i % 70 == 35) begin
        // overfill the ready queue, then park waiters, broadcast into it, drain it and broadcast again
        for (int j = 0; j < 18; j++) queue_op(lcq_pkg::OP_CREATE, 4'(j), 4'd0, 4'd0);
        for (int j = 0; j < 4; j++) queue_op(lcq_pkg::OP_WAIT, 4'(j), 4'd7, 4'd9);
        queue_op(lcq_pkg::OP_BROADCAST, 4'd0, 4'd0, 4'd9);
        for (int j = 0; j < 18; j++) queue_op(lcq_pkg::OP_DISPATCH, 4'd0, 4'd0, 4'd0);
        queue_op(lcq_pkg::OP_BROADCAST, 4'd0, 4'd0, 4'd9, 1'b1);
      end
      queue_random();
    end
  end

  // driver
  always @(posedge clk) begin
    int idle_pct;
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_sync(s_tdata);
        n_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        idle_pct = n_sent < 130 ? 26 : n_sent < 260 ? 69 : 0;
        if (pending.size() > 0 && (!pending[0].drain || expected_results.size() == 0) &&
            $urandom_range(0, 99) >= idle_pct) begin
          s_tdata <= pending[0].data;
          s_tvalid <= 1;
          void'(pending.pop_front());
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    lcq_pkg::res_t e;
    int idle_pct;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected transfer: data %h last %b", m_tdata, m_tlast);
        end else begin
          e = expected_results.pop_front();
          if (m_tdata[2:0] !== e.status || m_tdata[3] !== e.moved_valid ||
              m_tdata[7:4] !== e.moved_thread || m_tdata[8] !== e.retired ||
              m_tdata[9] !== e.granted || m_tdata[10] !== e.blocked || m_tlast !== e.last) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: expected st %0d mv %b mt %0d ret %b gr %b bl %b last %b, got data %h last %b",
                       e.status, e.moved_valid, e.moved_thread, e.retired, e.granted,
                       e.blocked, e.last, m_tdata, m_tlast);
          end
        end
      end
      if (!hold_done && n_sent == 60) begin
        hold_done <= 1;
        hold_left <= 300;
        m_tready <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 0;
      end else begin
        idle_pct = n_sent < 130 ? 69 : n_sent < 260 ? 26 : 0;
        m_tready <= $urandom_range(0, 99) >= idle_pct;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !s_tvalid && expected_results.size() == 0);
    repeat (40) @(posedge clk);
    if (n_mismatch == 0 && expected_results.size() == 0)
      $display("lock_condvar_queue_manager_unit verification clean");
    else
      $display("lock_condvar_queue_manager_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("lock_condvar_queue_manager_unit verification failed");
    $finish;
  end
endmodule
